### rtl/bit_plane_context_former_defines.svh
// Assertion macros shared by the context former modules.
// Each macro expects the module to have clk and rst_n in scope.
`ifndef BIT_PLANE_CONTEXT_FORMER_DEFINES_SVH
`define BIT_PLANE_CONTEXT_FORMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bpcf_pkg.sv
package bpcf_pkg;

  // Template walk: nine neighbour reads per query in either mode.
  localparam int STEP_W    = 4;
  localparam int NUM_STEPS = 9;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // Fixed field widths.
  localparam int ACC_W   = 13;
  localparam int POS_W   = 4;
  localparam int DIM_W   = 7;
  localparam int PLANE_W = 4;
  localparam int COORD_W = 6;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes on the configuration port.
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WIDTH  = 2'd0;
  localparam reg_idx_t REG_HEIGHT = 2'd1;
  localparam reg_idx_t REG_FIRST  = 2'd2;

  // Register reset values.
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 7'd64;
  localparam logic [PLANE_W-1:0] FIRST_RST  = 4'd15;

  // Neighbour offsets in three-bit two's complement.
  localparam logic [2:0] OFS_M2 = 3'b110;
  localparam logic [2:0] OFS_M1 = 3'b111;
  localparam logic [2:0] OFS_Z  = 3'b000;
  localparam logic [2:0] OFS_P1 = 3'b001;
  localparam logic [2:0] OFS_P2 = 3'b010;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [PLANE_W-1:0] first_plane;
  } cfg_t;

  typedef struct packed {
    logic              take_write;
    logic              take_query;
    logic              rd_issue;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // One template slot: offset, plane above or current, bit position, and
  // whether it moves up one position when (+1,-2) lies outside.
  typedef struct packed {
    logic [2:0]       dx;
    logic [2:0]       dy;
    logic             up;
    logic [POS_W-1:0] pos;
    logic             shifts;
  } step_t;

  function automatic step_t step_lookup(input logic first, input logic [STEP_W-1:0] idx);
    step_t s;
    s = '0;
    if (first) begin
      // 2D template on the first coded plane.
      unique case (idx)
        4'd0:    s = '{dx: OFS_M1, dy: OFS_M2, up: 1'b0, pos: 4'd1,  shifts: 1'b0};
        4'd1:    s = '{dx: OFS_Z,  dy: OFS_M2, up: 1'b0, pos: 4'd2,  shifts: 1'b0};
        4'd2:    s = '{dx: OFS_M2, dy: OFS_M1, up: 1'b0, pos: 4'd4,  shifts: 1'b1};
        4'd3:    s = '{dx: OFS_M1, dy: OFS_M1, up: 1'b0, pos: 4'd5,  shifts: 1'b1};
        4'd4:    s = '{dx: OFS_Z,  dy: OFS_M1, up: 1'b0, pos: 4'd6,  shifts: 1'b1};
        4'd5:    s = '{dx: OFS_P1, dy: OFS_M1, up: 1'b0, pos: 4'd7,  shifts: 1'b1};
        4'd6:    s = '{dx: OFS_P2, dy: OFS_M1, up: 1'b0, pos: 4'd8,  shifts: 1'b1};
        4'd7:    s = '{dx: OFS_M2, dy: OFS_Z,  up: 1'b0, pos: 4'd9,  shifts: 1'b1};
        4'd8:    s = '{dx: OFS_M1, dy: OFS_Z,  up: 1'b0, pos: 4'd10, shifts: 1'b1};
        default: s = '0;
      endcase
    end else begin
      // Plus-shaped window one plane up, then four causal neighbours.
      unique case (idx)
        4'd0:    s = '{dx: OFS_Z,  dy: OFS_M1, up: 1'b1, pos: 4'd1,  shifts: 1'b0};
        4'd1:    s = '{dx: OFS_M1, dy: OFS_Z,  up: 1'b1, pos: 4'd3,  shifts: 1'b0};
        4'd2:    s = '{dx: OFS_Z,  dy: OFS_Z,  up: 1'b1, pos: 4'd4,  shifts: 1'b0};
        4'd3:    s = '{dx: OFS_P1, dy: OFS_Z,  up: 1'b1, pos: 4'd5,  shifts: 1'b0};
        4'd4:    s = '{dx: OFS_Z,  dy: OFS_P1, up: 1'b1, pos: 4'd7,  shifts: 1'b0};
        4'd5:    s = '{dx: OFS_M1, dy: OFS_M1, up: 1'b0, pos: 4'd9,  shifts: 1'b0};
        4'd6:    s = '{dx: OFS_Z,  dy: OFS_M1, up: 1'b0, pos: 4'd10, shifts: 1'b0};
        4'd7:    s = '{dx: OFS_P1, dy: OFS_M1, up: 1'b0, pos: 4'd11, shifts: 1'b0};
        4'd8:    s = '{dx: OFS_M1, dy: OFS_Z,  up: 1'b0, pos: 4'd12, shifts: 1'b0};
        default: s = '0;
      endcase
    end
    return s;
  endfunction

endpackage

### rtl/bit_plane_context_former.sv
// A write transaction is accepted while idle and stored at that clock edge.
// A query transaction walks nine template slots, one read of the pixel memory
// per cycle, then passes through the drain and done states to the output register.
// No transaction is taken until the result loads, which an output stall delays.
// Reset (rst_n low, synchronous) clears control, output valid and the registers
// to width 64, height 64, first plane 15; the pixel memory is not cleared.
module bit_plane_context_former #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int CHANNELS   = 4,
  parameter int PIXEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [1:0]  in_channel,
  input  logic [5:0]  in_pos_col,
  input  logic [5:0]  in_pos_row,
  input  logic [15:0] in_pixel_value,
  input  logic [3:0]  in_plane,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_context_id,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bpcf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  bpcf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Sequencer for the template walk.
  bpcf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Pixel memory, neighbour addressing and context accumulation.
  bpcf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg            (cfg),
    .in_channel     (in_channel),
    .in_pos_col     (in_pos_col),
    .in_pos_row     (in_pos_row),
    .in_pixel_value (in_pixel_value),
    .in_plane       (in_plane),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_context_id (out_context_id)
  );

endmodule

### rtl/bpcf_regs.sv
module bpcf_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output bpcf_pkg::cfg_t     cfg
);
  import bpcf_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width       <= WIDTH_RST;
      cfg_r.height      <= HEIGHT_RST;
      cfg_r.first_plane <= FIRST_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  cfg_r.width       <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_r.height      <= cfg_pwdata[DIM_W-1:0];
        REG_FIRST:  cfg_r.first_plane <= cfg_pwdata[PLANE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back, zero extended.
  always_comb begin
    unique case (idx)
      REG_WIDTH:  cfg_prdata = 32'(cfg_r.width);
      REG_HEIGHT: cfg_prdata = 32'(cfg_r.height);
      REG_FIRST:  cfg_prdata = 32'(cfg_r.first_plane);
      default:    cfg_prdata = '0;
    endcase
  end

endmodule

### rtl/bpcf_ctrl.sv
`include "bit_plane_context_former_defines.svh"

module bpcf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_stall,
  input  bpcf_pkg::status_t status,
  output bpcf_pkg::cmd_t    cmd
);
  import bpcf_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  // State and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state: a query walks the template, then drains the last read and
  // waits for the output register.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation == OP_QUERY) begin
          state_nxt = ST_READ;
          cnt_nxt   = '0;
        end
      end
      ST_READ: begin
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (in_operation)
            OP_WRITE: cmd.take_write = 1'b1;
            OP_QUERY: cmd.take_query = 1'b1;
            default:  ;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        cmd.step     = cnt_r;
      end
      ST_DRAIN: ;
      ST_DONE:  cmd.load_out = status.out_free;
      default:  ;
    endcase
  end

  `BPCF_ASSERT_NEXT(a_query_starts_walk, cmd.take_query, state_r == ST_READ && cnt_r == '0, "query did not start the template walk at step zero")
  `BPCF_ASSERT_NEXT(a_walk_ends, state_r == ST_READ && cnt_r == LAST_STEP, state_r == ST_DRAIN, "template walk did not end after the last step")
  `BPCF_ASSERT_NOW(a_no_take_when_busy, state_r != ST_IDLE, in_stall && !cmd.take_query && !cmd.take_write, "transaction taken while a query is in progress")

endmodule

### rtl/bpcf_dp.sv
`include "bit_plane_context_former_defines.svh"

module bpcf_dp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int CHANNELS   = 4,
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bpcf_pkg::cmd_t                  cmd,
  output bpcf_pkg::status_t               status,
  input  bpcf_pkg::cfg_t                  cfg,
  input  logic [1:0]                      in_channel,
  input  logic [bpcf_pkg::COORD_W-1:0]    in_pos_col,
  input  logic [bpcf_pkg::COORD_W-1:0]    in_pos_row,
  input  logic [15:0]                     in_pixel_value,
  input  logic [bpcf_pkg::PLANE_W-1:0]    in_plane,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpcf_pkg::ACC_W-1:0]      out_context_id
);
  import bpcf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = CH_W + ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // Pixel memory: one write port, one registered read port.
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_word_r;

  // Query latched at acceptance.
  logic [1:0]         q_ch_r;
  logic [COORD_W-1:0] q_col_r, q_row_r;
  logic [PLANE_W-1:0] q_plane_r;
  logic               q_first_r, q_shift_r;

  // Read in flight, folded in on the cycle after it is issued.
  logic               pend_r, pend_use_r;
  logic [POS_W-1:0]   pend_pos_r;
  logic [PLANE_W:0]   pend_k_r;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               out_valid_r;
  logic [ACC_W-1:0]   out_ctx_r;

  step_t                 info;
  logic [7:0]            nc, nr;
  logic                  in_pic, in_store, use_bit;
  logic [POS_W-1:0]      pos;
  logic [PLANE_W:0]      k;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic                  wr_en;
  logic                  shift_now;
  logic [PIXEL_BITS-1:0] rd_shift;

  // Neighbour position and bounds for the current template step.
  always_comb begin
    info     = step_lookup(q_first_r, cmd.step);
    nc       = {2'b00, q_col_r} + {{5{info.dx[2]}}, info.dx};
    nr       = {2'b00, q_row_r} + {{5{info.dy[2]}}, info.dy};
    in_pic   = !nc[7] && !nr[7] && (nc[6:0] < cfg.width) && (nr[6:0] < cfg.height);
    in_store = (32'(nc[6:0]) < MAX_WIDTH) && (32'(nr[6:0]) < MAX_HEIGHT)
               && (32'(q_ch_r) < CHANNELS);
    use_bit  = in_pic && in_store;
    pos      = info.pos + POS_W'(info.shifts && q_shift_r);
    k        = {1'b0, q_plane_r} + {{PLANE_W{1'b0}}, info.up};
    rd_addr  = {CH_W'(q_ch_r), ROW_W'(nr[6:0]), COL_W'(nc[6:0])};
  end

  // Write address and range check for a pixel write.
  assign wr_addr = {CH_W'(in_channel), ROW_W'(in_pos_row), COL_W'(in_pos_col)};
  assign wr_en   = cmd.take_write && (32'(in_channel) < CHANNELS)
                   && (32'(in_pos_col) < MAX_WIDTH) && (32'(in_pos_row) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= PIXEL_BITS'(in_pixel_value);
    end
    if (cmd.rd_issue) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // The (+1,-2) slot lies outside the picture: later slots move up one bit.
  assign shift_now = ({1'b0, in_pos_col} + 7'd1 >= cfg.width) || (in_pos_row < 6'd2)
                     || ({1'b0, in_pos_row} - 7'd2 >= cfg.height);

  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      q_ch_r    <= in_channel;
      q_col_r   <= in_pos_col;
      q_row_r   <= in_pos_row;
      q_plane_r <= in_plane;
      q_first_r <= (in_plane == cfg.first_plane);
      q_shift_r <= shift_now;
    end
  end

  // Bookkeeping for the read in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    pend_use_r <= use_bit;
    pend_pos_r <= pos;
    pend_k_r   <= k;
  end

  // Fold the fetched bit into its slot of the context number.
  always_comb begin
    rd_shift = rd_word_r >> pend_k_r;
    acc_nxt  = acc_r;
    if (cmd.take_query) begin
      acc_nxt = '0;
    end else if (pend_r && pend_use_r) begin
      acc_nxt = acc_r | (ACC_W'(rd_shift[0]) << pend_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ctx_r <= acc_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_context_id  = out_ctx_r;
  assign status.out_free = !out_valid_r || !out_stall;

  `BPCF_ASSERT_NEXT(a_result_loaded, cmd.load_out, out_valid && out_context_id == $past(acc_r), "result register did not take the finished context number")

endmodule
